// ===== hw/rtl/bfl_pkg.sv =====
// bfl_pkg: shared constants, register codes and result type of the box filter
// no dependencies; used by the interfaces, the output queue and the top level
package bfl_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned WIDTH_CFG_W = 6;
  localparam int unsigned LEN_CFG_W   = 13;

  localparam int unsigned MAX_WINDOW = 63;
  localparam int unsigned MAX_LINE   = 4096;

  localparam logic [WIDTH_CFG_W-1:0] WIDTH_RST = WIDTH_CFG_W'(3);
  localparam logic [LEN_CFG_W-1:0]   LEN_RST   = LEN_CFG_W'(640);

  localparam int unsigned OQ_DEPTH = 8;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  typedef enum logic [0:0] {
    REG_WINDOW_WIDTH = 1'b0,
    REG_LINE_LENGTH  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             line_end;
    logic [PIX_W-1:0] pixel;
  } res_t;

endpackage

// ===== hw/rtl/bfl_if.sv =====
// bfl_in_if / bfl_out_if: valid-ready channels for source pixels and averages
// depends on bfl_pkg for the pixel width
interface bfl_in_if;
  logic                       valid;
  logic                       ready;
  logic [bfl_pkg::PIX_W-1:0]  in_pixel;

  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface

interface bfl_out_if;
  logic                       valid;
  logic                       ready;
  logic [bfl_pkg::PIX_W-1:0]  out_pixel;
  logic                       line_end;

  modport source (output valid, output out_pixel, output line_end, input ready);
  modport sink   (input valid, input out_pixel, input line_end, output ready);
endinterface

// ===== hw/rtl/box_filter_line_replicate.sv =====
// box_filter_line_replicate: 1-d running-sum box filter with edge replication
// depends on bfl_pkg, bfl_if (bfl_in_if, bfl_out_if), bfl_ram and bfl_oq
//
//   channel   dir   handshake                 beat
//   in_bus    in    valid/ready               in_pixel
//   out_bus   out   valid/ready               out_pixel, line_end
//   apb       in    psel/penable, pready=1    window_width @0x0, line_length @0x4
//
// one ring push per cycle through the ram port while the result queue has room:
// mid-line pixels are pushed once, first and last pixels half+1 times (w if both)
// an emitting push reaches out_bus via ram read, sum, multiply and queue, in order
// an 8-beat result queue absorbs out_bus stalls; pushes stop when it could overflow
// synchronous active-low reset, no memory clearing pass
module box_filter_line_replicate #(
  parameter int unsigned MAX_WINDOW = bfl_pkg::MAX_WINDOW,
  parameter int unsigned MAX_LINE   = bfl_pkg::MAX_LINE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bfl_in_if.sink                      in_bus,
  bfl_out_if.source                   out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfl_pkg::APB_AW-1:0]  paddr,
  input  logic [bfl_pkg::APB_DW-1:0]  pwdata,
  output logic [bfl_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned PIX_W   = bfl_pkg::PIX_W;
  localparam int unsigned WW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W   = $clog2(MAX_WINDOW * 255 + 1);
  localparam int unsigned SH      = SUM_W + WW;
  localparam int unsigned M_W     = SH + 1;
  localparam int unsigned PROD_W  = SUM_W + M_W;
  localparam int unsigned POS_W   = $clog2(MAX_LINE);
  localparam int unsigned LEN_W   = $clog2(MAX_LINE + 1);
  localparam int unsigned MAX_ODD = MAX_WINDOW - ((MAX_WINDOW % 2 == 0) ? 1 : 0);
  localparam int unsigned TAB_N   = 1 << WW;
  localparam int unsigned OQ_D    = bfl_pkg::OQ_DEPTH;
  localparam int unsigned LVL_W   = $clog2(OQ_D + 1);
  localparam int unsigned CR_W    = LVL_W + 2;

  // configuration
  logic [bfl_pkg::WIDTH_CFG_W-1:0] ww_r;
  logic [bfl_pkg::LEN_CFG_W-1:0]   ll_r;
  logic                            cfg_wr;
  bfl_pkg::reg_idx_t               reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = bfl_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ww_r <= bfl_pkg::WIDTH_RST;
      ll_r <= bfl_pkg::LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bfl_pkg::REG_WINDOW_WIDTH: ww_r <= pwdata[bfl_pkg::WIDTH_CFG_W-1:0];
        bfl_pkg::REG_LINE_LENGTH:  ll_r <= pwdata[bfl_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bfl_pkg::REG_WINDOW_WIDTH: prdata = bfl_pkg::APB_DW'(ww_r);
      bfl_pkg::REG_LINE_LENGTH:  prdata = bfl_pkg::APB_DW'(ll_r);
      default:                   prdata = '0;
    endcase
  end

  // effective width and length
  logic [31:0]      w_raw, l_raw;
  logic [WW-1:0]    eff_w;
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    w_raw = 32'(ww_r) | 32'd1;
    if (w_raw > MAX_WINDOW) begin
      w_raw = MAX_ODD;
    end
    eff_w = WW'(w_raw);
    l_raw = 32'(ll_r);
    if (l_raw == 32'd0) begin
      l_raw = 32'd1;
    end else if (l_raw > MAX_LINE) begin
      l_raw = MAX_LINE;
    end
    eff_len = LEN_W'(l_raw);
  end

  // reciprocal table for the divide by the window width
  logic [M_W-1:0] recip_tab [TAB_N];

  for (genvar d = 0; d < TAB_N; d++) begin : g_recip
    if (d == 0) begin : g_zero
      assign recip_tab[d] = '0;
    end else begin : g_val
      localparam longint unsigned RC =
        ((64'd1 << SH) + longint'(d) - 64'd1) / longint'(d);
      assign recip_tab[d] = M_W'(RC);
    end
  end

  // push sequencer
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [WW-1:0]    rem_r, rem_nxt;
  logic             last_r, last_nxt;
  logic             first_r, first_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [WW-1:0]    cur_w_r, cur_w_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [WW-1:0]    fill_r, fill_nxt;

  logic             accept, issue, credit_ok, pos0, line_last;
  logic [WW-1:0]    acc_w, acc_half, acc_n, idx_inc;
  logic             push_full, push_emit;
  logic [CR_W-1:0]  credit;
  logic [LVL_W-1:0] oq_level;

  // pipeline registers
  logic             s2_v_r, s2_full_r, s2_emit_r, s2_first_r, s2_end_r, fwd_r;
  logic [IDX_W-1:0] s2_addr_r;
  logic [PIX_W-1:0] s2_pix_r, fwd_pix_r;
  logic [M_W-1:0]   s2_m_r;
  logic             s3_v_r, s3_end_r;
  logic [SUM_W-1:0] s3_sum_r;
  logic [M_W-1:0]   s3_m_r;
  logic             s4_v_r, s4_end_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic [SUM_W-1:0] sum_r, sum_new, sum_base;
  logic [PIX_W-1:0] ram_rdata, old_pix;

  assign credit = CR_W'(oq_level) + CR_W'(s2_v_r & s2_emit_r)
                + CR_W'(s3_v_r) + CR_W'(s4_v_r);
  assign credit_ok = (credit < CR_W'(OQ_D));
  assign issue     = (rem_r != '0) && credit_ok;
  assign in_bus.ready = (rem_r == '0) || ((rem_r == WW'(1)) && issue);
  assign accept    = in_bus.valid && in_bus.ready;

  assign pos0      = (pos_r == '0);
  assign acc_w     = pos0 ? eff_w : cur_w_r;
  assign acc_half  = acc_w >> 1;
  assign line_last = pos0 ? (eff_len == LEN_W'(1))
                          : ((LEN_W'(pos_r) + LEN_W'(1)) == cur_len_r);
  assign acc_n     = WW'(1) + (pos0 ? acc_half : '0) + (line_last ? acc_half : '0);

  assign push_full = (fill_r == cur_w_r);
  assign push_emit = push_full || ((fill_r + WW'(1)) == cur_w_r);
  assign idx_inc   = WW'(idx_r) + WW'(1);

  always_comb begin
    pix_nxt     = pix_r;
    rem_nxt     = rem_r;
    last_nxt    = last_r;
    first_nxt   = first_r;
    pos_nxt     = pos_r;
    cur_w_nxt   = cur_w_r;
    cur_len_nxt = cur_len_r;
    idx_nxt     = idx_r;
    fill_nxt    = fill_r;
    if (issue) begin
      rem_nxt   = rem_r - WW'(1);
      first_nxt = 1'b0;
      idx_nxt   = (idx_inc == cur_w_r) ? '0 : IDX_W'(idx_inc);
      fill_nxt  = push_full ? fill_r : fill_r + WW'(1);
    end
    if (accept) begin
      pix_nxt   = in_bus.in_pixel;
      rem_nxt   = acc_n;
      last_nxt  = line_last;
      first_nxt = pos0;
      pos_nxt   = line_last ? '0 : pos_r + POS_W'(1);
      if (pos0) begin
        cur_w_nxt   = eff_w;
        cur_len_nxt = eff_len;
        idx_nxt     = '0;
        fill_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      last_r    <= 1'b0;
      first_r   <= 1'b0;
      pos_r     <= '0;
      cur_w_r   <= WW'(1);
      cur_len_r <= LEN_W'(1);
      idx_r     <= '0;
      fill_r    <= '0;
      sum_r     <= '0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      last_r    <= last_nxt;
      first_r   <= first_nxt;
      pos_r     <= pos_nxt;
      cur_w_r   <= cur_w_nxt;
      cur_len_r <= cur_len_nxt;
      idx_r     <= idx_nxt;
      fill_r    <= fill_nxt;
      if (s2_v_r) begin
        sum_r <= sum_new;
      end
      s2_v_r <= issue;
      s3_v_r <= s2_v_r && s2_emit_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    if (issue) begin
      s2_addr_r  <= idx_r;
      s2_pix_r   <= pix_r;
      s2_full_r  <= push_full;
      s2_emit_r  <= push_emit;
      s2_first_r <= first_r;
      s2_end_r   <= last_r && (rem_r == WW'(1));
      s2_m_r     <= recip_tab[cur_w_r];
      fwd_r      <= s2_v_r && (s2_addr_r == idx_r);
      fwd_pix_r  <= s2_pix_r;
    end
    s3_sum_r  <= sum_new;
    s3_m_r    <= s2_m_r;
    s3_end_r  <= s2_end_r;
    s4_prod_r <= PROD_W'(s3_sum_r) * PROD_W'(s3_m_r);
    s4_end_r  <= s3_end_r;
  end

  // ring of padded pixels
  bfl_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (s2_v_r),
    .waddr (s2_addr_r),
    .wdata (s2_pix_r),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign old_pix  = fwd_r ? fwd_pix_r : ram_rdata;
  assign sum_base = s2_first_r ? '0 : sum_r;
  assign sum_new  = sum_base - (s2_full_r ? SUM_W'(old_pix) : '0) + SUM_W'(s2_pix_r);

  // result queue
  bfl_pkg::res_t oq_wdata, oq_rdata;

  assign oq_wdata.line_end = s4_end_r;
  assign oq_wdata.pixel    = s4_prod_r[SH +: PIX_W];

  bfl_oq #(
    .DEPTH (OQ_D)
  ) u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (s4_v_r),
    .wr_data  (oq_wdata),
    .rd_valid (out_bus.valid),
    .rd_ready (out_bus.ready),
    .rd_data  (oq_rdata),
    .level    (oq_level)
  );

  assign out_bus.out_pixel = oq_rdata.pixel;
  assign out_bus.line_end  = oq_rdata.line_end;

endmodule

// ===== hw/rtl/bfl_ram.sv =====
// bfl_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module bfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bfl_oq.sv =====
// bfl_oq: small result queue between the divide pipeline and the output channel
// depends on bfl_pkg for the result type
module bfl_oq #(
  parameter int unsigned DEPTH = bfl_pkg::OQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  bfl_pkg::res_t                wr_data,
  output logic                         rd_valid,
  input  logic                         rd_ready,
  output bfl_pkg::res_t                rd_data,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  bfl_pkg::res_t   q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign rd_valid = (cnt_r != '0);
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = q_r[rd_ptr_r];
  assign level    = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + LW'(wr_en) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
